>>> design/spt_pkg.sv
// Package for the shot peak tracker: item codes, phase codes, field widths and the
// structs passed between the front, the queue and the back.
// No dependencies.
package spt_pkg;

  typedef enum logic [1:0] {
    MODE_UPDATE  = 2'd0,
    MODE_RESOLVE = 2'd1,
    MODE_ENTER   = 2'd2,
    MODE_EXIT    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_ESPRESSO_MAJOR   = 3'd0,
    REG_POST_POUR_WINDOW = 3'd1,
    REG_DIP_RATIO        = 3'd2,
    REG_DIP_FALLBACK     = 3'd3,
    REG_MIN_PEAK_FLOW    = 3'd4
  } cfg_reg_t;

  localparam logic [7:0] PHASE_HEAT      = 8'h02;
  localparam logic [7:0] PHASE_PREINFUSE = 8'h04;
  localparam logic [7:0] PHASE_POUR      = 8'h05;
  localparam logic [7:0] PHASE_FLUSH     = 8'h06;

  localparam int CODE_W     = 8;
  localparam int WEIGHT_W   = 24;
  localparam int READ_W     = 16;
  localparam int NOW_W      = 40;
  localparam int DEADLINE_W = NOW_W + 1;
  localparam int SPAN_W     = 24;
  localparam int RATIO_W    = 7;
  localparam int SCALED_W   = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int S_TDATA_W = 144;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 72;
  localparam int M_TUSER_W = 2;

  localparam logic [SCALED_W-1:0] PERCENT_SCALE = 23'd100;

  typedef struct packed {
    logic [CODE_W-1:0]  espresso_major;
    logic [SPAN_W-1:0]  post_pour_window;
    logic [RATIO_W-1:0] dip_ratio;
    logic [SPAN_W-1:0]  dip_fallback;
    logic [READ_W-1:0]  min_peak_flow;
  } cfg_t;

  typedef struct packed {
    mode_t                       mode;
    logic                        in_session;
    logic                        in_pour;
    logic                        pour_entry;
    logic                        pour_exit;
    logic                        busy;
    logic signed [WEIGHT_W-1:0]  weight;
    logic [READ_W-1:0]           shot_time;
    logic [READ_W-1:0]           pressure;
    logic [READ_W-1:0]           flow;
    logic [SCALED_W-1:0]         flow_scaled;
    logic [NOW_W-1:0]            now;
    logic [DEADLINE_W-1:0]       window_end;
  } item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [READ_W-1:0]          shot_time;
    logic [READ_W-1:0]          pressure;
    logic [READ_W-1:0]          flow;
    logic                       show;
    logic                       live;
  } result_t;

endpackage

>>> design/spt_front.sv
// Front of the shot peak tracker: unpacks an input beat and classifies it.
// Depends on spt_pkg.
module spt_front (
  input  logic [spt_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [spt_pkg::S_TUSER_W-1:0] s_tuser,
  input  spt_pkg::cfg_t                 cfg,
  output spt_pkg::item_t                item
);

  logic [spt_pkg::CODE_W-1:0] phase;
  logic [spt_pkg::CODE_W-1:0] prev_phase;
  logic [spt_pkg::CODE_W-1:0] prior_major;
  logic [spt_pkg::READ_W-1:0] flow;
  logic [spt_pkg::NOW_W-1:0]  now;

  assign phase       = s_tdata[8:1];
  assign prev_phase  = s_tdata[16:9];
  assign prior_major = s_tdata[24:17];
  assign flow        = s_tdata[96:81];
  assign now         = s_tdata[136:97];

  always_comb begin
    item.mode        = spt_pkg::mode_t'(s_tuser);
    item.in_session  = s_tdata[0];
    item.in_pour     = (phase == spt_pkg::PHASE_POUR);
    item.pour_entry  = (phase == spt_pkg::PHASE_POUR) &&
                       ((prev_phase != spt_pkg::PHASE_POUR) ||
                        (prior_major != cfg.espresso_major));
    item.pour_exit   = (prev_phase == spt_pkg::PHASE_POUR) &&
                       (phase != spt_pkg::PHASE_POUR);
    item.busy        = (phase == spt_pkg::PHASE_HEAT) ||
                       (phase == spt_pkg::PHASE_PREINFUSE) ||
                       (phase == spt_pkg::PHASE_POUR) ||
                       (phase == spt_pkg::PHASE_FLUSH);
    item.weight      = s_tdata[48:25];
    item.shot_time   = s_tdata[64:49];
    item.pressure    = s_tdata[80:65];
    item.flow        = flow;
    item.flow_scaled = {7'd0, flow} * spt_pkg::PERCENT_SCALE;
    item.now         = now;
    item.window_end  = {1'b0, now} + {17'd0, cfg.post_pour_window};
  end

endmodule

>>> design/spt_queue.sv
// Short first-in first-out queue of classified items between front and back.
// Depends on spt_pkg.
module spt_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  spt_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output spt_pkg::item_t pop_item
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(DEPTH);

  spt_pkg::item_t     entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               push;
  logic               pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("queue count above depth");
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && count == FULL_CNT - 1'b1) |=> !push_ready)
    else $error("queue did not report full");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && count == COUNT_W'(1)) |=> !pop_valid)
    else $error("queue did not report empty");

endmodule

>>> design/spt_back.sv
// Back of the shot peak tracker: session state, peak tracking and the result register.
// Depends on spt_pkg.
module spt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  spt_pkg::cfg_t                 cfg,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  spt_pkg::item_t                item,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [spt_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [spt_pkg::M_TUSER_W-1:0] m_tuser
);

  logic signed [spt_pkg::WEIGHT_W-1:0] peak_weight;
  logic [spt_pkg::READ_W-1:0]          peak_pressure;
  logic [spt_pkg::READ_W-1:0]          peak_flow;
  logic [spt_pkg::READ_W-1:0]          pour_flow_high;
  logic                                flow_armed;
  logic [spt_pkg::NOW_W-1:0]           pour_start_time;
  logic                                pour_start_valid;
  logic [spt_pkg::DEADLINE_W-1:0]      window_deadline;
  logic                                window_valid;
  logic signed [spt_pkg::WEIGHT_W-1:0] saved_weight;
  logic [spt_pkg::READ_W-1:0]          saved_pressure;
  logic [spt_pkg::READ_W-1:0]          saved_flow;
  logic [spt_pkg::READ_W-1:0]          saved_time;
  logic                                saved_valid;

  spt_pkg::result_t                    result;
  spt_pkg::result_t                    result_next;
  logic                                pop;

  logic [spt_pkg::READ_W-1:0]          high_base;
  logic [spt_pkg::READ_W-1:0]          high_next;
  logic                                armed_base;
  logic [spt_pkg::SCALED_W-1:0]        dip_limit;
  logic                                dip;
  logic [spt_pkg::DEADLINE_W-1:0]      fallback_end;
  logic                                fallback;
  logic [spt_pkg::READ_W-1:0]          flow_base;
  logic                                armed_next;
  logic [spt_pkg::READ_W-1:0]          peak_flow_next;
  logic                                in_window;

  assign item_ready = (item.mode != spt_pkg::MODE_RESOLVE) || !m_tvalid || m_tready;
  assign pop        = item_valid && item_ready;

  // Flow maximum arming; an entry into pour in the same beat restarts the pour.
  always_comb begin
    high_base      = item.pour_entry ? '0 : pour_flow_high;
    high_next      = (item.flow > high_base) ? item.flow : high_base;
    armed_base     = item.pour_entry ? 1'b0 : flow_armed;
    dip_limit      = {7'd0, high_next} * {16'd0, cfg.dip_ratio};
    dip            = (high_next > cfg.min_peak_flow) && (item.flow_scaled < dip_limit);
    fallback_end   = {1'b0, pour_start_time} + {17'd0, cfg.dip_fallback};
    if (item.pour_entry) begin
      fallback = (cfg.dip_fallback == '0);
    end else begin
      fallback = pour_start_valid && ({1'b0, item.now} >= fallback_end);
    end
    flow_base      = (!armed_base && dip) ? '0 : peak_flow;
    armed_next     = armed_base || dip || fallback;
    peak_flow_next = (armed_next && (item.flow > flow_base)) ? item.flow : flow_base;
    in_window      = item.in_pour || item.pour_exit ||
                     (window_valid && ({1'b0, item.now} <= window_deadline));
  end

  always_comb begin
    result_next = '0;
    if (item.in_session) begin
      result_next.show      = 1'b1;
      result_next.shot_time = item.shot_time;
      if (item.busy) begin
        result_next.live   = 1'b1;
        result_next.weight = item.weight;
        if (item.in_pour) begin
          result_next.pressure = item.pressure;
          result_next.flow     = item.flow;
        end
      end else begin
        result_next.weight   = peak_weight;
        result_next.pressure = peak_pressure;
        result_next.flow     = peak_flow;
      end
    end else if (saved_valid) begin
      result_next.show      = 1'b1;
      result_next.weight    = saved_weight;
      result_next.shot_time = saved_time;
      result_next.pressure  = saved_pressure;
      result_next.flow      = saved_flow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_weight      <= '0;
      peak_pressure    <= '0;
      peak_flow        <= '0;
      pour_flow_high   <= '0;
      flow_armed       <= 1'b0;
      pour_start_time  <= '0;
      pour_start_valid <= 1'b0;
      window_deadline  <= '0;
      window_valid     <= 1'b0;
      saved_weight     <= '0;
      saved_pressure   <= '0;
      saved_flow       <= '0;
      saved_time       <= '0;
      saved_valid      <= 1'b0;
    end else if (pop) begin
      case (item.mode)
        spt_pkg::MODE_UPDATE: begin
          if (item.in_session) begin
            if (item.pour_entry) begin
              pour_start_time  <= item.now;
              pour_start_valid <= 1'b1;
            end
            if (item.pour_exit) begin
              window_deadline <= item.window_end;
              window_valid    <= 1'b1;
            end
            if (in_window && (item.weight > peak_weight)) begin
              peak_weight <= item.weight;
            end
            if (item.in_pour) begin
              if (item.pressure > peak_pressure) begin
                peak_pressure <= item.pressure;
              end
              pour_flow_high <= high_next;
              flow_armed     <= armed_next;
              peak_flow      <= peak_flow_next;
            end
          end
        end
        spt_pkg::MODE_ENTER, spt_pkg::MODE_EXIT: begin
          if (item.mode == spt_pkg::MODE_EXIT) begin
            saved_weight   <= peak_weight;
            saved_pressure <= peak_pressure;
            saved_flow     <= peak_flow;
            saved_time     <= item.shot_time;
            saved_valid    <= 1'b1;
          end else begin
            saved_weight   <= '0;
            saved_pressure <= '0;
            saved_flow     <= '0;
            saved_time     <= '0;
            saved_valid    <= 1'b0;
          end
          peak_weight      <= '0;
          peak_pressure    <= '0;
          peak_flow        <= '0;
          pour_flow_high   <= '0;
          flow_armed       <= 1'b0;
          pour_start_time  <= '0;
          pour_start_valid <= 1'b0;
          window_deadline  <= '0;
          window_valid     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && (item.mode == spt_pkg::MODE_RESOLVE)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (item.mode == spt_pkg::MODE_RESOLVE)) begin
      result <= result_next;
    end
  end

  assign m_tdata = {result.flow, result.pressure, result.shot_time, result.weight};
  assign m_tuser = {result.live, result.show};

  a_enter_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && item.mode == spt_pkg::MODE_ENTER) |=> (!saved_valid && peak_weight == '0))
    else $error("enter beat did not clear the session");
  a_exit_saves: assert property (@(posedge clk) disable iff (rst)
    (pop && item.mode == spt_pkg::MODE_EXIT) |=> (saved_valid && !window_valid))
    else $error("exit beat did not save the session");
  a_resolve_result: assert property (@(posedge clk) disable iff (rst)
    (pop && item.mode == spt_pkg::MODE_RESOLVE) |=> m_tvalid)
    else $error("resolve beat produced no result");

endmodule

>>> design/shot_peak_tracker.sv
// Top level of the shot peak tracker: configuration registers, front, queue and back.
// Depends on spt_pkg, spt_front, spt_queue and spt_back.
//
//   channel   direction  handshake              payload
//   s_*       in         s_tvalid / s_tready    s_tdata sample fields, s_tuser mode
//   m_*       out        m_tvalid / m_tready    m_tdata displayed values, m_tuser flags
//   cfg_*     in         cfg_valid / cfg_ready  cfg_index register, cfg_data value
//
// One beat is taken per cycle while the queue has room (s_tready high); each beat is carried
// out by the back when it leaves the queue. A resolve beat raises m_tvalid at the edge after
// the back accepts it.
// Resolve beats wait in the queue only while the result register is full and m_tready is low.
// Synchronous reset clears the queue and session state and loads the default configuration.
// Configuration writes are taken in every cycle.
module shot_peak_tracker #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // in_session, phase_code, prev_phase_code, prev_major_code, weight_in,
  // shot_time_in, pressure_in, flow_in, now_us, zero fill
  input  logic [spt_pkg::S_TDATA_W-1:0]    s_tdata,
  // mode
  input  logic [spt_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // weight_out, shot_time_out, pressure_out, flow_out
  output logic [spt_pkg::M_TDATA_W-1:0]    m_tdata,
  // show, live
  output logic [spt_pkg::M_TUSER_W-1:0]    m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  spt_pkg::cfg_t  cfg;
  spt_pkg::item_t front_item;
  spt_pkg::item_t queue_item;
  logic           queue_valid;
  logic           queue_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.espresso_major   <= 8'd4;
      cfg.post_pour_window <= 24'd2000000;
      cfg.dip_ratio        <= 7'd70;
      cfg.dip_fallback     <= 24'd4000000;
      cfg.min_peak_flow    <= 16'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spt_pkg::REG_ESPRESSO_MAJOR:   cfg.espresso_major   <= cfg_data[7:0];
        spt_pkg::REG_POST_POUR_WINDOW: cfg.post_pour_window <= cfg_data;
        spt_pkg::REG_DIP_RATIO:        cfg.dip_ratio        <= cfg_data[6:0];
        spt_pkg::REG_DIP_FALLBACK:     cfg.dip_fallback     <= cfg_data;
        spt_pkg::REG_MIN_PEAK_FLOW:    cfg.min_peak_flow    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  spt_front u_front (
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cfg     (cfg),
    .item    (front_item)
  );

  spt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  spt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

>>> dv/shot_peak_checker.sv
// Beat layout of the sample channel and the scoreboard of the shot peak tracker bench.
// The scoreboard mirrors the configuration, predicts each display beat and compares it.
// Depends on spt_pkg.
package spt_beat_pkg;
  import spt_pkg::*;

  // Sample channel tdata, listed from the top bit down to bit 0.
  typedef struct packed {
    logic [6:0]                 fill;
    logic [NOW_W-1:0]           now;
    logic [READ_W-1:0]          flow;
    logic [READ_W-1:0]          pressure;
    logic [READ_W-1:0]          shot_time;
    logic signed [WEIGHT_W-1:0] weight;
    logic [CODE_W-1:0]          prior_major;
    logic [CODE_W-1:0]          prev_phase;
    logic [CODE_W-1:0]          phase;
    logic                       in_session;
  } sample_t;
endpackage

module shot_peak_checker
  import spt_pkg::*;
  import spt_beat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic [S_TUSER_W-1:0]  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  input  logic [M_TUSER_W-1:0]  m_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  logic [CODE_W-1:0]          major_code;
  logic [SPAN_W-1:0]          window_span;
  logic [RATIO_W-1:0]         dip_pct;
  logic [SPAN_W-1:0]          fallback_span;
  logic [READ_W-1:0]          min_flow;

  logic signed [WEIGHT_W-1:0] top_weight;
  logic [READ_W-1:0]          top_pressure;
  logic [READ_W-1:0]          top_flow;
  logic [READ_W-1:0]          pour_high;
  logic                       flow_armed;
  logic [NOW_W-1:0]           pour_t0;
  logic                       pour_t0_ok;
  logic [DEADLINE_W-1:0]      window_end;
  logic                       window_ok;

  logic signed [WEIGHT_W-1:0] kept_weight;
  logic [READ_W-1:0]          kept_pressure;
  logic [READ_W-1:0]          kept_flow;
  logic [READ_W-1:0]          kept_time;
  logic                       kept_ok;

  result_t display_q[$];
  int      fail_count = 0;

  task automatic clear_session();
    top_weight = '0;
    top_pressure = '0;
    top_flow = '0;
    pour_high = '0;
    flow_armed = 1'b0;
    pour_t0 = '0;
    pour_t0_ok = 1'b0;
    window_end = '0;
    window_ok = 1'b0;
  endtask

  task automatic clear_all();
    clear_session();
    kept_weight = '0;
    kept_pressure = '0;
    kept_flow = '0;
    kept_time = '0;
    kept_ok = 1'b0;
  endtask

  task automatic advance_session(input mode_t op, input sample_t s);
    result_t    r;
    logic       in_pour;
    logic       dip;
    logic [31:0] flow_pct;
    logic [31:0] high_pct;
    r = '0;
    in_pour = (s.phase == PHASE_POUR);
    case (op)
      MODE_UPDATE: begin
        if (s.in_session) begin
          if (in_pour && (s.prev_phase != PHASE_POUR || s.prior_major != major_code)) begin
            pour_t0 = s.now;
            pour_t0_ok = 1'b1;
            pour_high = '0;
            flow_armed = 1'b0;
          end
          if (s.prev_phase == PHASE_POUR && !in_pour) begin
            window_end = {1'b0, s.now} + DEADLINE_W'(window_span);
            window_ok = 1'b1;
          end
          if (in_pour || (window_ok && {1'b0, s.now} <= window_end)) begin
            if ($signed(s.weight) > top_weight) top_weight = s.weight;
          end
          if (in_pour) begin
            if (s.pressure > top_pressure) top_pressure = s.pressure;
            if (s.flow > pour_high) pour_high = s.flow;
            if (!flow_armed) begin
              flow_pct = 32'(s.flow) * 32'd100;
              high_pct = 32'(pour_high) * 32'(dip_pct);
              dip = (pour_high > min_flow) && (flow_pct < high_pct);
              // A dip restarts the maximum; the fallback time only arms it.
              if (dip) begin
                top_flow = '0;
                flow_armed = 1'b1;
              end else if (pour_t0_ok &&
                           {1'b0, s.now} >= {1'b0, pour_t0} + DEADLINE_W'(fallback_span)) begin
                flow_armed = 1'b1;
              end
            end
            if (flow_armed && s.flow > top_flow) top_flow = s.flow;
          end
        end
      end
      MODE_ENTER: clear_all();
      MODE_EXIT: begin
        kept_weight = top_weight;
        kept_pressure = top_pressure;
        kept_flow = top_flow;
        kept_time = s.shot_time;
        kept_ok = 1'b1;
        clear_session();
      end
      MODE_RESOLVE: begin
        if (s.in_session) begin
          r.show = 1'b1;
          r.shot_time = s.shot_time;
          if (s.phase inside {PHASE_HEAT, PHASE_PREINFUSE, PHASE_POUR, PHASE_FLUSH}) begin
            r.live = 1'b1;
            r.weight = s.weight;
            if (in_pour) begin
              r.pressure = s.pressure;
              r.flow = s.flow;
            end
          end else begin
            r.weight = top_weight;
            r.pressure = top_pressure;
            r.flow = top_flow;
          end
        end else if (kept_ok) begin
          r.show = 1'b1;
          r.weight = kept_weight;
          r.shot_time = kept_time;
          r.pressure = kept_pressure;
          r.flow = kept_flow;
        end
        display_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [WEIGHT_W-1:0] want,
                             input logic [WEIGHT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      major_code = 8'd4;
      window_span = 24'd2000000;
      dip_pct = 7'd70;
      fallback_span = 24'd4000000;
      min_flow = 16'd50;
      clear_all();
      display_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.weight = m_tdata[23:0];
        got.shot_time = m_tdata[39:24];
        got.pressure = m_tdata[55:40];
        got.flow = m_tdata[71:56];
        got.show = m_tuser[0];
        got.live = m_tuser[1];
        if (display_q.size() == 0) begin
          $display("%0t: display beat with nothing expected, expected none, got 0x%0h",
                   $time, got);
          fail_count++;
        end else begin
          want = display_q.pop_front();
          check_field("weight", want.weight, got.weight);
          check_field("shot_time", WEIGHT_W'(want.shot_time), WEIGHT_W'(got.shot_time));
          check_field("pressure", WEIGHT_W'(want.pressure), WEIGHT_W'(got.pressure));
          check_field("flow", WEIGHT_W'(want.flow), WEIGHT_W'(got.flow));
          check_field("show", WEIGHT_W'(want.show), WEIGHT_W'(got.show));
          check_field("live", WEIGHT_W'(want.live), WEIGHT_W'(got.live));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ESPRESSO_MAJOR:   major_code = cfg_data[CODE_W-1:0];
          REG_POST_POUR_WINDOW: window_span = cfg_data[SPAN_W-1:0];
          REG_DIP_RATIO:        dip_pct = cfg_data[RATIO_W-1:0];
          REG_DIP_FALLBACK:     fallback_span = cfg_data[SPAN_W-1:0];
          REG_MIN_PEAK_FLOW:    min_flow = cfg_data[READ_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) advance_session(mode_t'(s_tuser), sample_t'(s_tdata));
    end
    errors <= fail_count;
    pending <= display_q.size();
  end

endmodule

>>> dv/shot_peak_tracker_tb.sv
// Top of the shot peak tracker bench: clock, reset, sample and configuration stimulus,
// random stalls on the display channel, a watchdog and the verdict.
// Depends on spt_pkg, spt_beat_pkg, shot_peak_checker and shot_peak_tracker.
module shot_peak_tracker_tb;
  import spt_pkg::*;
  import spt_beat_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ROUND_ITEMS   = 175;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int send_idle = 0;
  int recv_idle = 0;
  int stall_cycles = 0;
  int sent = 0;
  int step_max = 1500000;
  int weight_level = 0;
  logic [NOW_W-1:0]  clock_us = '0;
  logic [CODE_W-1:0] last_phase = '0;
  logic [CODE_W-1:0] major_code = 8'd4;

  shot_peak_tracker dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  shot_peak_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic sample_t noise();
    sample_t s;
    s.fill = '0;
    s.now = {8'($urandom), $urandom};
    s.flow = 16'($urandom);
    s.pressure = 16'($urandom);
    s.shot_time = 16'($urandom);
    s.weight = 24'($urandom);
    s.prior_major = 8'($urandom);
    s.prev_phase = 8'($urandom);
    s.phase = 8'($urandom);
    s.in_session = 1'($urandom);
    return s;
  endfunction

  function automatic sample_t mk(input logic sess, input logic [7:0] ph, input logic [7:0] pph,
                                 input logic [7:0] pmaj, input logic [23:0] w,
                                 input logic [15:0] t, input logic [15:0] p,
                                 input logic [15:0] f, input logic [39:0] now);
    sample_t s;
    s = '0;
    s.in_session = sess;
    s.phase = ph;
    s.prev_phase = pph;
    s.prior_major = pmaj;
    s.weight = w;
    s.shot_time = t;
    s.pressure = p;
    s.flow = f;
    s.now = now;
    return s;
  endfunction

  function automatic logic [7:0] any_phase();
    case ($urandom_range(5))
      0: return PHASE_HEAT;
      1: return PHASE_PREINFUSE;
      2: return PHASE_POUR;
      3: return PHASE_FLUSH;
      4: return 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_beat(input mode_t op, input sample_t s);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata <= s;
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Holds the sample channel until every display beat is back and the pipeline is empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] maj, input logic [23:0] window,
                           input logic [6:0] ratio, input logic [23:0] fallback,
                           input logic [15:0] min_flow);
    settle();
    write_reg(REG_ESPRESSO_MAJOR, CFG_DATA_W'(maj));
    write_reg(REG_POST_POUR_WINDOW, window);
    write_reg(REG_DIP_RATIO, CFG_DATA_W'(ratio));
    write_reg(REG_DIP_FALLBACK, fallback);
    write_reg(REG_MIN_PEAK_FLOW, CFG_DATA_W'(min_flow));
    major_code = maj;
  endtask

  task automatic peek();
    sample_t s;
    s = noise();
    s.in_session = ($urandom_range(3) != 0);
    s.phase = any_phase();
    send_beat(MODE_RESOLVE, s);
  endtask

  task automatic shot_sample(input logic [7:0] ph);
    sample_t s;
    case ($urandom_range(3))
      0: ;
      1: clock_us += 40'($urandom_range(1000));
      default: clock_us += 40'($urandom_range(step_max));
    endcase
    weight_level += int'($urandom_range(400)) - 60;
    s = noise();
    s.in_session = ($urandom_range(15) != 0);
    s.phase = ph;
    s.prev_phase = last_phase;
    if ($urandom_range(9) != 0) s.prior_major = major_code;
    if ($urandom_range(15) != 0) s.weight = 24'(weight_level);
    if ($urandom_range(15) != 0) s.pressure = 16'($urandom_range(1200));
    if ($urandom_range(15) != 0) s.flow = 16'($urandom_range(900));
    s.now = clock_us;
    send_beat(MODE_UPDATE, s);
    last_phase = ph;
    if ($urandom_range(3) == 0) peek();
  endtask

  task automatic run_shot();
    sample_t s;
    if ($urandom_range(7) == 0) clock_us = 40'hFF_FFFF_FFFF - 40'($urandom_range(8000000));
    if ($urandom_range(4) != 0) send_beat(MODE_ENTER, noise());
    weight_level = int'($urandom_range(200)) - 100;
    last_phase = 8'd0;
    repeat ($urandom_range(3)) shot_sample($urandom_range(1) ? PHASE_HEAT : PHASE_PREINFUSE);
    repeat ($urandom_range(2, 14)) shot_sample(PHASE_POUR);
    repeat ($urandom_range(1, 6)) shot_sample(any_phase());
    if ($urandom_range(5) == 0) repeat ($urandom_range(1, 4)) shot_sample(PHASE_POUR);
    send_beat(MODE_EXIT, noise());
    repeat ($urandom_range(2)) begin
      s = noise();
      s.in_session = 1'b0;
      send_beat(MODE_RESOLVE, s);
    end
    if ($urandom_range(11) == 0) settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed sequence under the reset configuration.
    send_beat(MODE_RESOLVE, mk(0, 8'd0, 8'd0, 8'd0, 24'd0, 16'd0, 16'd0, 16'd0, 40'd0));
    send_beat(MODE_ENTER, mk(0, 8'd0, 8'd0, 8'd0, 24'd0, 16'd0, 16'd0, 16'd0, 40'd0));
    send_beat(MODE_UPDATE, mk(0, PHASE_POUR, PHASE_PREINFUSE, 8'd4, 24'd9000, 16'd0,
                              16'd9000, 16'd9000, 40'd50));
    send_beat(MODE_UPDATE, mk(1, PHASE_POUR, PHASE_PREINFUSE, 8'd4, 24'd500, 16'd0,
                              16'd900, 16'd400, 40'd100));
    send_beat(MODE_UPDATE, mk(1, PHASE_POUR, PHASE_POUR, 8'd4, 24'd700, 16'd10,
                              16'hFFFF, 16'hFFFF, 40'd200));
    send_beat(MODE_RESOLVE, mk(1, PHASE_POUR, 8'd0, 8'd0, 24'h800000, 16'hFFFF,
                               16'hFFFF, 16'hFFFF, 40'd0));
    send_beat(MODE_RESOLVE, mk(1, PHASE_HEAT, 8'd0, 8'd0, 24'h7FFFFF, 16'd1,
                               16'd77, 16'd88, 40'd0));
    send_beat(MODE_UPDATE, mk(1, PHASE_POUR, PHASE_POUR, 8'd4, 24'd800, 16'd20,
                              16'd100, 16'd0, 40'd300));
    send_beat(MODE_UPDATE, mk(1, PHASE_POUR, PHASE_POUR, 8'd4, 24'd900, 16'd30,
                              16'd100, 16'd1200, 40'd400));
    send_beat(MODE_UPDATE, mk(1, PHASE_FLUSH, PHASE_POUR, 8'd4, 24'd950, 16'd40,
                              16'd2000, 16'd2000, 40'd1000000));
    send_beat(MODE_UPDATE, mk(1, 8'd0, PHASE_FLUSH, 8'd4, 24'd1500, 16'd50,
                              16'd0, 16'd0, 40'd3000000));
    send_beat(MODE_UPDATE, mk(1, 8'd0, 8'd0, 8'd4, 24'd2000, 16'd60,
                              16'd0, 16'd0, 40'd3000001));
    send_beat(MODE_RESOLVE, mk(1, 8'hFF, 8'd0, 8'd0, 24'd0, 16'd70, 16'd0, 16'd0, 40'd0));
    send_beat(MODE_EXIT, mk(0, 8'd0, 8'd0, 8'd0, 24'd0, 16'hFFFF, 16'd0, 16'd0, 40'd0));
    send_beat(MODE_RESOLVE, mk(0, PHASE_POUR, 8'd0, 8'd0, 24'd1, 16'd2, 16'd3, 16'd4, 40'd5));
    // Pour entry through a change of major state, then arming by the fallback time.
    send_beat(MODE_UPDATE, mk(1, PHASE_POUR, PHASE_POUR, 8'd3, 24'd100, 16'd0,
                              16'd300, 16'd40, 40'd5000000));
    send_beat(MODE_UPDATE, mk(1, PHASE_POUR, PHASE_POUR, 8'd4, 24'd110, 16'd0,
                              16'd300, 16'd20, 40'd8999999));
    send_beat(MODE_UPDATE, mk(1, PHASE_POUR, PHASE_POUR, 8'd4, 24'd120, 16'd0,
                              16'd300, 16'd30, 40'd9000000));
    send_beat(MODE_RESOLVE, mk(1, 8'd0, 8'd0, 8'd0, 24'd0, 16'd5, 16'd0, 16'd0, 40'd0));
    // Window opened at the top of the timestamp range.
    send_beat(MODE_UPDATE, mk(1, PHASE_POUR, PHASE_FLUSH, 8'd4, 24'd130, 16'd0,
                              16'd300, 16'd30, 40'hFF_FFFF_FFFF));
    send_beat(MODE_UPDATE, mk(1, PHASE_FLUSH, PHASE_POUR, 8'd4, 24'h7FFFFF, 16'd0,
                              16'd300, 16'd30, 40'hFF_FFFF_FFFF));
    send_beat(MODE_RESOLVE, mk(1, 8'd0, 8'd0, 8'd0, 24'd0, 16'd6, 16'd0, 16'd0, 40'd0));
    send_beat(MODE_ENTER, mk(1, 8'd0, 8'd0, 8'd0, 24'd0, 16'd0, 16'd0, 16'd0, 40'd0));
    send_beat(MODE_RESOLVE, mk(0, 8'd0, 8'd0, 8'd0, 24'd0, 16'd0, 16'd0, 16'd0, 40'd0));
    send_beat(MODE_EXIT, mk(0, 8'd0, 8'd0, 8'd0, 24'd0, 16'd0, 16'd0, 16'd0, 40'd0));

    for (int round = 0; round < 9; round++) begin
      case (round / 3)
        0: begin send_idle = 35; recv_idle = 72; end
        1: begin send_idle = 72; recv_idle = 35; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (round)
        0: configure(8'd4, 24'd2000000, 7'd70, 24'd4000000, 16'd50);
        1: configure(8'd0, 24'd0, 7'd0, 24'd0, 16'd0);
        2: configure(8'hFF, 24'hFFFFFF, 7'd100, 24'hFFFFFF, 16'hFFFF);
        default: configure($urandom_range(1) ? 8'd4 : 8'($urandom),
                           24'($urandom_range(3000000)), 7'($urandom_range(100)),
                           24'($urandom_range(6000000)), 16'($urandom_range(600)));
      endcase
      for (int target = sent + ROUND_ITEMS; sent < target; ) begin
        if ($urandom_range(9) == 0) send_beat(mode_t'($urandom_range(3)), noise());
        else run_shot();
      end
    end

    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
